// ===== hdl/ordered_list_insert_delete_top_macros.svh =====
// ----------------------------------------------------------------------------
// ordered list assertion macros
// clocked assertion shorthands used by the checker file
// ----------------------------------------------------------------------------
`ifndef ORDERED_LIST_INSERT_DELETE_TOP_MACROS_SVH
`define ORDERED_LIST_INSERT_DELETE_TOP_MACROS_SVH

// same-cycle implication, disabled during reset
`define OLID_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("olid check failed");

// next-cycle implication, disabled during reset
`define OLID_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("olid check failed");

`endif

// ===== hdl/olid_pkg.sv =====
// ----------------------------------------------------------------------------
// ordered list package
// operation and status codes, controller states and command struct
// ----------------------------------------------------------------------------
package olid_pkg;

	localparam int unsigned WORD_W  = 32;
	localparam int unsigned MODE_W  = 3;
	localparam int unsigned POS_W   = 5;
	localparam int unsigned COUNT_W = 5;

	// number of word cells; the count and position fields are sized for it
	localparam int unsigned CAPACITY = 16;

	typedef enum logic [MODE_W-1:0] {
		MODE_INS_FRONT = 3'd0,
		MODE_INS_BACK  = 3'd1,
		MODE_INS_POS   = 3'd2,
		MODE_REM_FRONT = 3'd3,
		MODE_REM_BACK  = 3'd4,
		MODE_REM_POS   = 3'd5
	} olid_mode_t;

	typedef enum logic [1:0] {
		STAT_OK    = 2'd0,
		STAT_FULL  = 2'd1,
		STAT_EMPTY = 2'd2,
		STAT_RANGE = 2'd3
	} olid_status_t;

	typedef enum logic {
		CTRL_IDLE = 1'b0,
		CTRL_HOLD = 1'b1
	} olid_state_t;

	typedef struct packed {
		logic exec;
	} olid_cmd_t;

endpackage

// ===== hdl/olid_ctrl.sv =====
// ----------------------------------------------------------------------------
// ordered list controller
// handshake state machine; issues one execute command per transaction
// ----------------------------------------------------------------------------
module olid_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               out_stall,
	output logic               in_stall,
	output logic               out_valid,
	output olid_pkg::olid_cmd_t cmd
);

	olid_pkg::olid_state_t state_q, state_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= olid_pkg::CTRL_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	// outputs
	always_comb begin
		out_valid = (state_q == olid_pkg::CTRL_HOLD);
		in_stall  = (state_q == olid_pkg::CTRL_HOLD) && out_stall;
		cmd.exec  = in_valid && !in_stall;
	end

	// next state
	always_comb begin
		case (state_q)
			olid_pkg::CTRL_IDLE: begin
				state_next = cmd.exec ? olid_pkg::CTRL_HOLD : olid_pkg::CTRL_IDLE;
			end
			olid_pkg::CTRL_HOLD: begin
				if (cmd.exec || out_stall) begin
					state_next = olid_pkg::CTRL_HOLD;
				end else begin
					state_next = olid_pkg::CTRL_IDLE;
				end
			end
			default: begin
				state_next = olid_pkg::CTRL_IDLE;
			end
		endcase
	end

endmodule

// ===== hdl/olid_datapath.sv =====
// ----------------------------------------------------------------------------
// ordered list datapath
// row of shifting word cells, length counter and result registers
// ----------------------------------------------------------------------------
module olid_datapath (
	input  logic                                clk,
	input  logic                                arst_n,
	input  olid_pkg::olid_cmd_t                 cmd,
	input  logic [olid_pkg::MODE_W-1:0]         mode,
	input  logic [olid_pkg::WORD_W-1:0]         value,
	input  logic [olid_pkg::POS_W-1:0]          position,
	input  logic                                auto_middle,
	output logic [1:0]                          status,
	output logic [olid_pkg::WORD_W-1:0]         removed_value,
	output logic [olid_pkg::COUNT_W-1:0]        entry_count
);

	localparam int unsigned CAPACITY = olid_pkg::CAPACITY;
	localparam int unsigned IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int unsigned CW = $clog2(CAPACITY + 1);
	localparam int unsigned PW = ((CW > olid_pkg::POS_W) ? CW : olid_pkg::POS_W) + 1;

	logic [olid_pkg::WORD_W-1:0] cell_q [CAPACITY];
	logic [CW-1:0]               length_q;
	olid_pkg::olid_status_t      status_q;
	logic [olid_pkg::WORD_W-1:0] removed_q;
	logic [CW-1:0]               count_q;

	olid_pkg::olid_status_t stat_c;
	logic                   do_ins, do_rem;
	logic [IW-1:0]          slot_c;
	logic                   full_c, empty_c;
	logic [PW-1:0]          pos_ext, len_ext;
	logic [CW-1:0]          length_next;

	assign full_c  = (length_q == CW'(CAPACITY));
	assign empty_c = (length_q == '0);
	assign pos_ext = PW'(position);
	assign len_ext = PW'(length_q);

	// decode the request against the current length
	always_comb begin
		stat_c = olid_pkg::STAT_OK;
		do_ins = 1'b0;
		do_rem = 1'b0;
		slot_c = '0;
		case (olid_pkg::olid_mode_t'(mode))
			olid_pkg::MODE_INS_FRONT: begin
				if (full_c) stat_c = olid_pkg::STAT_FULL;
				else do_ins = 1'b1;
			end
			olid_pkg::MODE_INS_BACK: begin
				slot_c = IW'(length_q);
				if (full_c) stat_c = olid_pkg::STAT_FULL;
				else do_ins = 1'b1;
			end
			olid_pkg::MODE_INS_POS: begin
				if (full_c) begin
					stat_c = olid_pkg::STAT_FULL;
				end else if (auto_middle) begin
					slot_c = IW'(length_q >> 1);
					if (empty_c) stat_c = olid_pkg::STAT_EMPTY;
					else do_ins = 1'b1;
				end else begin
					slot_c = IW'(pos_ext - PW'(1));
					if (pos_ext == '0 || pos_ext > len_ext + PW'(1)) begin
						stat_c = olid_pkg::STAT_RANGE;
					end else begin
						do_ins = 1'b1;
					end
				end
			end
			olid_pkg::MODE_REM_FRONT: begin
				if (empty_c) stat_c = olid_pkg::STAT_EMPTY;
				else do_rem = 1'b1;
			end
			olid_pkg::MODE_REM_BACK: begin
				slot_c = IW'(length_q - CW'(1));
				if (empty_c) stat_c = olid_pkg::STAT_EMPTY;
				else do_rem = 1'b1;
			end
			olid_pkg::MODE_REM_POS: begin
				slot_c = IW'(pos_ext - PW'(1));
				if (empty_c) begin
					stat_c = olid_pkg::STAT_EMPTY;
				end else if (pos_ext == '0 || pos_ext > len_ext) begin
					stat_c = olid_pkg::STAT_RANGE;
				end else begin
					do_rem = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		length_next = length_q;
		if (do_ins) length_next = length_q + CW'(1);
		else if (do_rem) length_next = length_q - CW'(1);
	end

	// each cell takes its left or right neighbor, the new word, or holds
	for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
		logic [olid_pkg::WORD_W-1:0] left_w, right_w;
		if (k == 0) begin : g_first
			assign left_w = value;
		end else begin : g_left
			assign left_w = cell_q[k-1];
		end
		if (k == CAPACITY - 1) begin : g_last
			assign right_w = cell_q[k];
		end else begin : g_right
			assign right_w = cell_q[k+1];
		end

		always_ff @(posedge clk) begin
			if (cmd.exec) begin
				if (do_ins && IW'(k) == slot_c) begin
					cell_q[k] <= value;
				end else if (do_ins && IW'(k) > slot_c) begin
					cell_q[k] <= left_w;
				end else if (do_rem && IW'(k) >= slot_c) begin
					cell_q[k] <= right_w;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			length_q <= '0;
		end else if (cmd.exec) begin
			length_q <= length_next;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			status_q  <= stat_c;
			removed_q <= do_rem ? cell_q[slot_c] : '0;
			count_q   <= length_next;
		end
	end

	assign status        = status_q;
	assign removed_value = removed_q;
	assign entry_count   = olid_pkg::COUNT_W'(count_q);

endmodule

// ===== hdl/ordered_list_insert_delete_top.sv =====
// ----------------------------------------------------------------------------
// ordered list insert/delete top level
// bounded ordered list of signed words with positional insert and remove
// ----------------------------------------------------------------------------
// usage:
//   input channel (in_valid/in_stall) carries one request per transaction:
//   mode, value, position and auto_middle. output channel
//   (out_valid/out_stall) returns status, removed_value and entry_count.
//   every request gives exactly one result transaction, in order.
// timing and throughput:
//   the result is registered and shows in the cycle after the request is taken.
//   one request per cycle is sustained while out_stall is low; the whole list
//   shifts at once as every cell loads from its neighbor in parallel.
// stall:
//   while a result is held and out_stall is high, in_stall is raised and
//   the held result stays unchanged. when the result is taken in the same
//   cycle, a new request is accepted and replaces it with no bubble.
// reset:
//   arst_n clears the length counter and the output valid; the word cells
//   are not cleared, only entries below the length are ever read.
// ----------------------------------------------------------------------------
module ordered_list_insert_delete_top (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// request channel
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic [olid_pkg::MODE_W-1:0]          mode,
	input  logic signed [olid_pkg::WORD_W-1:0]   value,
	input  logic [olid_pkg::POS_W-1:0]           position,
	input  logic                                 auto_middle,
	// result channel
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic [1:0]                           status,
	output logic signed [olid_pkg::WORD_W-1:0]   removed_value,
	output logic [olid_pkg::COUNT_W-1:0]         entry_count
);

	// command from controller to datapath
	olid_pkg::olid_cmd_t cmd;

	// handshake sequencing
	olid_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.out_stall (out_stall),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.cmd       (cmd)
	);

	// cell row, length and result registers
	olid_datapath u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.mode          (mode),
		.value         (value),
		.position      (position),
		.auto_middle   (auto_middle),
		.status        (status),
		.removed_value (removed_value),
		.entry_count   (entry_count)
	);

endmodule

// ===== hdl/olid_checker.sv =====
// ----------------------------------------------------------------------------
// ordered list port checker
// watches the top level ports for result handshake and consistency
// ----------------------------------------------------------------------------
`include "ordered_list_insert_delete_top_macros.svh"

module olid_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_stall,
	input logic                          out_valid,
	input logic                          out_stall,
	input logic [1:0]                    status,
	input logic [olid_pkg::WORD_W-1:0]   removed_value,
	input logic [olid_pkg::COUNT_W-1:0]  entry_count
);

	// a held result stays put
	`OLID_ASSERT_NEXT(a_hold, out_valid && out_stall, out_valid && $stable(removed_value) && $stable(entry_count))

	// every accepted request yields a result next cycle
	`OLID_ASSERT_NEXT(a_result, in_valid && !in_stall, out_valid)

	// count never exceeds the list capacity
	`OLID_ASSERT_NOW(a_count, out_valid, 32'(entry_count) <= olid_pkg::CAPACITY)

	// failed requests remove nothing
	`OLID_ASSERT_NOW(a_fail_zero, out_valid && status != olid_pkg::STAT_OK, removed_value == '0)

endmodule

bind ordered_list_insert_delete_top olid_checker u_olid_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (in_valid),
	.in_stall      (in_stall),
	.out_valid     (out_valid),
	.out_stall     (out_stall),
	.status        (status),
	.removed_value (removed_value),
	.entry_count   (entry_count)
);

// ===== test/testbench.sv =====
// ----------------------------------------------------------------------------
// ordered list insert/delete testbench
// drives positional insert and remove requests into the list block, keeps a
// shadow copy of the list to predict status, removed word and count for each
// request, and checks every result transaction in order against it
// ----------------------------------------------------------------------------
module testbench;

	localparam int CAPACITY   = olid_pkg::CAPACITY;
	localparam int IDLE_PCT   = 26;
	localparam int RAND_ITEMS = 600;
	localparam int HOLD_AT    = 200;   // result count that starts the long receiver hold
	localparam int HOLD_LEN   = 60;
	localparam int QUIET_LO   = 300;   // no idling on either side inside this window
	localparam int QUIET_HI   = 400;
	localparam int WATCHDOG   = 1500;
	localparam int TAIL       = 8;

	// mode codes left unused by the block
	localparam logic [olid_pkg::MODE_W-1:0] MODE_SPARE_LO = 3'd6;
	localparam logic [olid_pkg::MODE_W-1:0] MODE_SPARE_HI = 3'd7;

	typedef enum {GROW, SHRINK, MIXED} burst_kind_t;

	typedef struct {
		logic [olid_pkg::MODE_W-1:0]        mode;
		logic signed [olid_pkg::WORD_W-1:0] value;
		logic [olid_pkg::POS_W-1:0]         position;
		logic                               auto_middle;
		bit                                 drain_first;   // hold back until all results are in
	} list_req_t;

	typedef struct {
		olid_pkg::olid_status_t             st;
		logic signed [olid_pkg::WORD_W-1:0] word;
		logic [olid_pkg::COUNT_W-1:0]       count;
	} list_res_t;

	// clock, reset and block inputs, all known from time zero
	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic [olid_pkg::MODE_W-1:0] mode = '0;
	logic signed [olid_pkg::WORD_W-1:0] value = '0;
	logic [olid_pkg::POS_W-1:0] position = '0;
	logic auto_middle = 1'b0;
	logic out_stall = 1'b0;

	logic in_stall;
	logic out_valid;
	logic [1:0] status;
	logic signed [olid_pkg::WORD_W-1:0] removed_value;
	logic [olid_pkg::COUNT_W-1:0] entry_count;

	// stimulus waiting to go out, and results predicted for accepted requests
	list_req_t pending_req_q[$];
	list_res_t predicted_q[$];

	// shadow copy of the list contents
	logic signed [olid_pkg::WORD_W-1:0] shadow_list[CAPACITY];
	int shadow_len = 0;

	int n_accepted = 0;
	int n_results = 0;
	int n_fail = 0;
	int hold_left = 0;
	bit hold_done = 1'b0;
	int stuck_cycles = 0;
	list_req_t next_req;
	list_res_t head_res;

	ordered_list_insert_delete_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.mode(mode),
		.value(value),
		.position(position),
		.auto_middle(auto_middle),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.status(status),
		.removed_value(removed_value),
		.entry_count(entry_count)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// applies one request to the shadow list and returns what the block should report
	function automatic list_res_t apply_request(input list_req_t r);
		list_res_t res;
		bit do_ins;
		bit do_rem;
		int at;
		int k;
		res.st = olid_pkg::STAT_OK;
		res.word = '0;
		do_ins = 1'b0;
		do_rem = 1'b0;
		at = 0;
		if (r.mode == olid_pkg::MODE_INS_FRONT || r.mode == olid_pkg::MODE_INS_BACK ||
				r.mode == olid_pkg::MODE_INS_POS) begin
			// full wins over every other insert failure
			if (shadow_len >= CAPACITY) begin
				res.st = olid_pkg::STAT_FULL;
			end else if (r.mode == olid_pkg::MODE_INS_FRONT) begin
				do_ins = 1'b1;
				at = 0;
			end else if (r.mode == olid_pkg::MODE_INS_BACK) begin
				do_ins = 1'b1;
				at = shadow_len;
			end else if (r.auto_middle) begin
				// middle insert needs at least one entry
				if (shadow_len == 0) begin
					res.st = olid_pkg::STAT_EMPTY;
				end else begin
					do_ins = 1'b1;
					at = shadow_len / 2;
				end
			end else if (int'(r.position) < 1 || int'(r.position) > shadow_len + 1) begin
				res.st = olid_pkg::STAT_RANGE;
			end else begin
				do_ins = 1'b1;
				at = int'(r.position) - 1;
			end
		end else if (r.mode == olid_pkg::MODE_REM_FRONT || r.mode == olid_pkg::MODE_REM_BACK ||
				r.mode == olid_pkg::MODE_REM_POS) begin
			if (shadow_len == 0) begin
				res.st = olid_pkg::STAT_EMPTY;
			end else if (r.mode == olid_pkg::MODE_REM_FRONT) begin
				do_rem = 1'b1;
				at = 0;
			end else if (r.mode == olid_pkg::MODE_REM_BACK) begin
				do_rem = 1'b1;
				at = shadow_len - 1;
			end else if (int'(r.position) < 1 || int'(r.position) > shadow_len) begin
				res.st = olid_pkg::STAT_RANGE;
			end else begin
				do_rem = 1'b1;
				at = int'(r.position) - 1;
			end
		end
		// spare modes fall through: ok, nothing removed, list untouched
		if (do_ins) begin
			for (k = shadow_len; k > at; k--)
				shadow_list[k] = shadow_list[k-1];
			shadow_list[at] = r.value;
			shadow_len++;
		end
		if (do_rem) begin
			res.word = shadow_list[at];
			for (k = at; k + 1 < shadow_len; k++)
				shadow_list[k] = shadow_list[k+1];
			shadow_len--;
		end
		res.count = olid_pkg::COUNT_W'(shadow_len);
		return res;
	endfunction

	task automatic queue_req(input logic [olid_pkg::MODE_W-1:0] m,
			input logic signed [olid_pkg::WORD_W-1:0] v,
			input logic [olid_pkg::POS_W-1:0] p, input logic mid, input bit drain);
		list_req_t r;
		r.mode = m;
		r.value = v;
		r.position = p;
		r.auto_middle = mid;
		r.drain_first = drain;
		pending_req_q.push_back(r);
	endtask

	// random word, with the extremes showing up now and then
	function automatic logic signed [olid_pkg::WORD_W-1:0] pick_word();
		int roll;
		roll = $urandom_range(99);
		if (roll < 4)
			return 32'sh7fffffff;
		else if (roll < 8)
			return 32'sh80000000;
		else if (roll < 10)
			return -32'sd69;
		return $urandom;
	endfunction

	// mostly sensible positions, sometimes anything the field can hold
	function automatic logic [olid_pkg::POS_W-1:0] pick_pos();
		if ($urandom_range(99) < 15)
			return olid_pkg::POS_W'($urandom_range(31));
		return olid_pkg::POS_W'($urandom_range(17, 1));
	endfunction

	// driver: computes the expectation on each accepted transaction and
	// presents the next request, payload frozen while stalled
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			mode <= '0;
			value <= '0;
			position <= '0;
			auto_middle <= 1'b0;
		end else begin
			if (in_valid && !in_stall) begin
				next_req.mode = mode;
				next_req.value = value;
				next_req.position = position;
				next_req.auto_middle = auto_middle;
				next_req.drain_first = 1'b0;
				predicted_q.push_back(apply_request(next_req));
				n_accepted++;
			end
			if (!in_valid || !in_stall) begin
				// idle at random outside the quiet window; a drain point waits
				// for every outstanding result before going out
				if (pending_req_q.size() != 0 &&
						!((n_accepted < QUIET_LO || n_accepted >= QUIET_HI) &&
						$urandom_range(99) < IDLE_PCT) &&
						!(pending_req_q[0].drain_first && predicted_q.size() != 0)) begin
					next_req = pending_req_q.pop_front();
					in_valid <= 1'b1;
					mode <= next_req.mode;
					value <= next_req.value;
					position <= next_req.position;
					auto_middle <= next_req.auto_middle;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// monitor: checks each result transaction against the oldest prediction
	// and drives the receiver stall, including one long hold
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				n_results++;
				if (predicted_q.size() == 0) begin
					$error("result transaction with no request outstanding");
					n_fail++;
				end else begin
					head_res = predicted_q.pop_front();
					if (status !== head_res.st) begin
						$error("status: expected %0d, actual %0d", head_res.st, status);
						n_fail++;
					end
					if (removed_value !== head_res.word) begin
						$error("removed_value: expected %0d, actual %0d",
							head_res.word, removed_value);
						n_fail++;
					end
					if (entry_count !== head_res.count) begin
						$error("entry_count: expected %0d, actual %0d",
							head_res.count, entry_count);
						n_fail++;
					end
				end
			end
			if (hold_left != 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else if (!hold_done && n_results >= HOLD_AT) begin
				// long back-pressure so the block fills and stalls its input
				hold_done = 1'b1;
				hold_left = HOLD_LEN - 1;
				out_stall <= 1'b1;
			end else if (n_results >= QUIET_LO && n_results < QUIET_HI) begin
				out_stall <= 1'b0;
			end else begin
				out_stall <= ($urandom_range(99) < IDLE_PCT);
			end
		end
	end

	// watchdog: cycles in a row with no transaction on either channel
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				stuck_cycles <= 0;
			else
				stuck_cycles <= stuck_cycles + 1;
			if (stuck_cycles >= WATCHDOG) begin
				$display("== FAIL ==");
				$finish;
			end
		end
	end

	initial begin
		burst_kind_t kind;
		int burst;
		int n_gen;
		int roll;
		logic [olid_pkg::MODE_W-1:0] m;

		// directed part: empty-list failures first
		queue_req(olid_pkg::MODE_REM_FRONT, 32'sd0, 5'd1, 1'b0, 1'b0);
		queue_req(olid_pkg::MODE_REM_BACK, 32'sd0, 5'd1, 1'b1, 1'b0);
		queue_req(olid_pkg::MODE_REM_POS, 32'sd0, 5'd1, 1'b0, 1'b0);
		queue_req(olid_pkg::MODE_INS_POS, 32'sd5, 5'd1, 1'b1, 1'b0);   // middle insert, empty
		queue_req(olid_pkg::MODE_INS_POS, 32'sd5, 5'd0, 1'b0, 1'b0);   // position zero
		queue_req(olid_pkg::MODE_INS_POS, 32'sd5, 5'd2, 1'b0, 1'b0);   // past the end
		queue_req(MODE_SPARE_LO, 32'sh7fffffff, 5'd31, 1'b1, 1'b0);
		queue_req(MODE_SPARE_HI, 32'sh80000000, 5'd31, 1'b1, 1'b0);
		// back insert on empty list stores the only entry
		queue_req(olid_pkg::MODE_INS_BACK, 32'sh7fffffff, 5'd0, 1'b0, 1'b0);
		queue_req(olid_pkg::MODE_INS_FRONT, 32'sh80000000, 5'd31, 1'b1, 1'b0);
		queue_req(olid_pkg::MODE_INS_POS, 32'sd0, 5'd3, 1'b0, 1'b0);   // just past the last
		queue_req(olid_pkg::MODE_INS_POS, 32'sd1, 5'd31, 1'b0, 1'b0);  // far out of range
		queue_req(olid_pkg::MODE_INS_POS, -32'sd69, 5'd0, 1'b1, 1'b0); // middle insert
		queue_req(olid_pkg::MODE_INS_POS, -32'sd1, 5'd1, 1'b0, 1'b0);
		queue_req(olid_pkg::MODE_INS_BACK, 32'sh5a5a5a5a, 5'd16, 1'b1, 1'b0);
		queue_req(olid_pkg::MODE_REM_POS, 32'sd0, 5'd0, 1'b0, 1'b0);   // remove position zero
		queue_req(olid_pkg::MODE_REM_POS, 32'sd0, 5'd7, 1'b0, 1'b0);   // one past the end
		queue_req(olid_pkg::MODE_REM_POS, -32'sd1, 5'd1, 1'b1, 1'b0);  // position one, front
		queue_req(olid_pkg::MODE_REM_POS, 32'sd0, 5'd4, 1'b0, 1'b0);   // next-to-last entry by position
		queue_req(olid_pkg::MODE_REM_BACK, 32'sd0, 5'd0, 1'b0, 1'b0);
		queue_req(olid_pkg::MODE_REM_POS, 32'sd0, 5'd2, 1'b0, 1'b0);
		queue_req(olid_pkg::MODE_REM_FRONT, 32'sd0, 5'd0, 1'b0, 1'b0);
		queue_req(olid_pkg::MODE_REM_FRONT, 32'sd0, 5'd0, 1'b0, 1'b1); // empties the list, after a drain

		// random part: grow and shrink bursts push the list to full and empty
		n_gen = 0;
		while (n_gen < RAND_ITEMS) begin
			roll = $urandom_range(2);
			kind = (roll == 0) ? GROW : (roll == 1) ? SHRINK : MIXED;
			burst = $urandom_range(24, 8);
			repeat (burst) begin
				roll = $urandom_range(99);
				if (roll >= 97) begin
					m = ($urandom_range(1) == 0) ? MODE_SPARE_LO : MODE_SPARE_HI;
				end else if ((kind == GROW && roll < 82) || (kind == SHRINK && roll >= 82) ||
						(kind == MIXED && roll < 50)) begin
					roll = $urandom_range(2);
					m = (roll == 0) ? olid_pkg::MODE_INS_FRONT :
						(roll == 1) ? olid_pkg::MODE_INS_BACK : olid_pkg::MODE_INS_POS;
				end else begin
					roll = $urandom_range(2);
					m = (roll == 0) ? olid_pkg::MODE_REM_FRONT :
						(roll == 1) ? olid_pkg::MODE_REM_BACK : olid_pkg::MODE_REM_POS;
				end
				// auto_middle is random on every mode but only matters in mode 2
				queue_req(m, pick_word(), pick_pos(), ($urandom_range(99) < 35),
					(n_gen == 150 || n_gen == 450));
				n_gen++;
			end
		end

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// wait for the stimulus to drain, then for all results, then a short tail
		while (pending_req_q.size() != 0 || in_valid)
			@(posedge clk);
		while (predicted_q.size() != 0)
			@(posedge clk);
		repeat (TAIL) @(posedge clk);
		if (predicted_q.size() != 0) begin
			$error("%0d predicted results never arrived", predicted_q.size());
			n_fail++;
		end
		if (n_fail == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

// ===== ordered_list_insert_delete_top.f =====
+incdir+hdl
hdl/olid_pkg.sv
hdl/olid_ctrl.sv
hdl/olid_datapath.sv
hdl/ordered_list_insert_delete_top.sv
hdl/olid_checker.sv
test/testbench.sv
